[src/expiring_key_table_defines.svh]
// Assertion macros for the expiring key table.
`ifndef EXPIRING_KEY_TABLE_DEFINES_SVH
`define EXPIRING_KEY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define EKT_CHECK(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("expiring_key_table: check failed");
// Next-cycle implication, checked outside reset.
`define EKT_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("expiring_key_table: check failed");
`else
`define EKT_CHECK(name, ante, cons)
`define EKT_CHECK_NEXT(name, ante, cons)
`endif

`endif

[src/ekt_pkg.sv]
// Shared types and codes for the expiring key table.
package ekt_pkg;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_REMOVE = 2'd1,
    K_QUERY  = 2'd2,
    K_TICK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned FoundW = 32;
  localparam int unsigned LiveW  = 7;

  // Result of one request.
  typedef struct packed {
    status_e             status;
    logic [FoundW-1:0]   found_data;
    logic [LiveW-1:0]    live_count;
  } res_t;

  // Controller status seen by the top level.
  typedef struct packed {
    logic busy;     // request in progress
    logic done;     // result ready for the output register
    logic empty;    // no live entries
    logic tb_zero;  // time base is zero
    logic no_min;   // earliest deadline is all ones
  } stat_t;

endpackage

[src/ekt_cell.sv]
// One entry cell of the rotating entry ring.
module ekt_cell #(
  parameter int unsigned PW = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic                         valid_i,
  input  logic [ekt_pkg::KeyW-1:0]     key_i,
  input  logic [PW-1:0]                payload_i,
  input  logic [ekt_pkg::TimeW-1:0]    deadline_i,
  output logic                         valid_o,
  output logic [ekt_pkg::KeyW-1:0]     key_o,
  output logic [PW-1:0]                payload_o,
  output logic [ekt_pkg::TimeW-1:0]    deadline_o
);

  logic                      valid_q;
  logic [ekt_pkg::KeyW-1:0]  key_q;
  logic [PW-1:0]             payload_q;
  logic [ekt_pkg::TimeW-1:0] deadline_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q      <= key_i;
      payload_q  <= payload_i;
      deadline_q <= deadline_i;
    end
  end

  assign valid_o    = valid_q;
  assign key_o      = key_q;
  assign payload_o  = payload_q;
  assign deadline_o = deadline_q;

endmodule

[src/ekt_ctrl.sv]
// Request sequencer: walks the ring once per pass, matches, expires and tracks the minimum.
module ekt_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned PW       = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [1:0]                   kind_i,
  input  logic [ekt_pkg::KeyW-1:0]     key_i,
  input  logic [PW-1:0]                data_i,
  input  logic [ekt_pkg::TimeW-1:0]    timeout_i,
  input  logic [ekt_pkg::TimeW-1:0]    elapsed_i,
  input  logic                         take_i,
  input  logic                         head_valid_i,
  input  logic [ekt_pkg::KeyW-1:0]     head_key_i,
  input  logic [PW-1:0]                head_payload_i,
  input  logic [ekt_pkg::TimeW-1:0]    head_deadline_i,
  output logic                         fb_valid_o,
  output logic [ekt_pkg::KeyW-1:0]     fb_key_o,
  output logic [PW-1:0]                fb_payload_o,
  output logic [ekt_pkg::TimeW-1:0]    fb_deadline_o,
  output logic                         shift_o,
  output ekt_pkg::stat_t               stat_o,
  output ekt_pkg::res_t                res_o
);

  localparam int unsigned CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned NW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PASS = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             cnt_q;
  ekt_pkg::kind_e            kind_q;
  logic [ekt_pkg::KeyW-1:0]  key_q;
  logic [PW-1:0]             data_q;
  logic [ekt_pkg::TimeW-1:0] timeout_q;
  logic [ekt_pkg::TimeW-1:0] time_base_q;
  logic [ekt_pkg::TimeW-1:0] earliest_q;
  logic [NW-1:0]             count_q;
  logic [NW-1:0]             acc_n_q, acc_n_d;
  logic [ekt_pkg::TimeW-1:0] acc_m_q, acc_m_d;
  logic                      seen_q, free_q, wrote_q;
  ekt_pkg::status_e          status_q;
  logic [ekt_pkg::FoundW-1:0] found_q;

  logic                      hit, expire, last, seen_any, free_any, write_new;
  logic [ekt_pkg::TimeW-1:0] new_dl;

  assign hit      = head_valid_i && (head_key_i == key_q);
  assign expire   = head_valid_i && (head_deadline_i <= time_base_q);
  assign last     = (cnt_q == CW'(CAPACITY - 1));
  assign seen_any = seen_q | hit;
  assign free_any = free_q | !head_valid_i;
  assign new_dl   = timeout_q + time_base_q;
  assign write_new = (state_q == S_FILL) && !head_valid_i && !wrote_q;

  // Value written back at the tail of the ring.
  always_comb begin
    fb_valid_o    = head_valid_i;
    fb_key_o      = head_key_i;
    fb_payload_o  = head_payload_i;
    fb_deadline_o = head_deadline_i;
    if (state_q == S_PASS) begin
      if ((kind_q == ekt_pkg::K_REMOVE && hit) || (kind_q == ekt_pkg::K_TICK && expire)) begin
        fb_valid_o = 1'b0;
      end
    end
    if (write_new) begin
      fb_valid_o    = 1'b1;
      fb_key_o      = key_q;
      fb_payload_o  = data_q;
      fb_deadline_o = new_dl;
    end
  end

  // Survivor count and minimum deadline of this pass.
  assign acc_n_d = acc_n_q + NW'(fb_valid_o);
  assign acc_m_d = (fb_valid_o && (fb_deadline_o < acc_m_q)) ? fb_deadline_o : acc_m_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (ekt_pkg::kind_e'(kind_i) == ekt_pkg::K_TICK && count_q == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (last) begin
          if (kind_q == ekt_pkg::K_INSERT && !seen_any && free_any) begin
            state_d = S_FILL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_FILL: begin
        if (last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      time_base_q <= '0;
      earliest_q  <= '1;
      count_q     <= '0;
      acc_n_q     <= '0;
      acc_m_q     <= '1;
      seen_q      <= 1'b0;
      free_q      <= 1'b0;
      wrote_q     <= 1'b0;
      status_q    <= ekt_pkg::ST_OK;
      found_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q    <= '0;
            acc_n_q  <= '0;
            acc_m_q  <= '1;
            seen_q   <= 1'b0;
            free_q   <= 1'b0;
            wrote_q  <= 1'b0;
            status_q <= ekt_pkg::ST_OK;
            found_q  <= '0;
            if (ekt_pkg::kind_e'(kind_i) == ekt_pkg::K_TICK && count_q != '0) begin
              time_base_q <= time_base_q + elapsed_i;
            end
          end
        end
        S_PASS: begin
          cnt_q   <= last ? '0 : cnt_q + CW'(1);
          acc_n_q <= acc_n_d;
          acc_m_q <= acc_m_d;
          seen_q  <= seen_any;
          free_q  <= free_any;
          if (hit && (kind_q == ekt_pkg::K_REMOVE || kind_q == ekt_pkg::K_QUERY)) begin
            found_q <= ekt_pkg::FoundW'(head_payload_i);
          end
          if (last) begin
            if (kind_q == ekt_pkg::K_INSERT) begin
              if (seen_any) begin
                status_q <= ekt_pkg::ST_MISS;
              end else if (!free_any) begin
                status_q <= ekt_pkg::ST_FULL;
              end
            end else begin
              if (kind_q != ekt_pkg::K_TICK && !seen_any) begin
                status_q <= ekt_pkg::ST_MISS;
              end
              count_q    <= acc_n_d;
              earliest_q <= acc_m_d;
              if (acc_n_d == '0) begin
                time_base_q <= '0;
              end
            end
          end
        end
        S_FILL: begin
          cnt_q <= last ? '0 : cnt_q + CW'(1);
          if (write_new) begin
            wrote_q <= 1'b1;
          end
          if (last) begin
            count_q    <= count_q + NW'(1);
            earliest_q <= (new_dl < earliest_q) ? new_dl : earliest_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      kind_q    <= ekt_pkg::kind_e'(kind_i);
      key_q     <= key_i;
      data_q    <= data_i;
      timeout_q <= timeout_i;
    end
  end

  assign shift_o = (state_q == S_PASS) || (state_q == S_FILL);

  assign stat_o.busy    = (state_q != S_IDLE);
  assign stat_o.done    = (state_q == S_DONE);
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.tb_zero = (time_base_q == '0);
  assign stat_o.no_min  = (earliest_q == '1);

  assign res_o.status     = status_q;
  assign res_o.found_data = found_q;
  assign res_o.live_count = ekt_pkg::LiveW'(count_q);

endmodule

[src/expiring_key_table.sv]
// Top level of the expiring key table: entry ring, sequencer and output register.
//
// Usage:
// - Request channel: in_valid_i / in_stall_o with kind_i, key_i, entry_data_i,
//   timeout_ticks_i, elapsed_ticks_i. A request is taken when in_valid_i is high
//   and in_stall_o is low; in_stall_o stays high while a request is in progress.
// - Result channel: out_valid_o / out_stall_i with status_o, found_data_o,
//   live_count_o. Exactly one result per request, in request order.
// - Entries live in a ring of CAPACITY cells that rotates one place per cycle
//   while a pass runs; the sequencer sees one entry per cycle at the head and
//   writes it back at the tail, so one pass visits every entry once.
// - Remove, query, tick and a refused insert each take one ring pass before
//   out_valid_o; a successful insert takes a second pass that places the new
//   entry; a tick on an empty table takes no pass.
// - A new request is accepted only once the previous result has left the sequencer.
// - The output register holds a finished result while out_stall_i is high;
//   the next request is accepted meanwhile, and its result waits in the
//   sequencer until the register frees up.
// - Reset (rst_ni low, asynchronous) empties the table, clears the time base
//   and the live count, and drops any pending result. No clearing pass needed.
`include "expiring_key_table_defines.svh"

module expiring_key_table #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic signed [31:0] key_i,
  input  logic [31:0] entry_data_i,
  input  logic [31:0] timeout_ticks_i,
  input  logic [31:0] elapsed_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] found_data_o,
  output logic [6:0]  live_count_o
);

  // Stored payload width: the input carries 32 bits at most.
  localparam int unsigned PW = (DATA_WIDTH < ekt_pkg::FoundW) ? DATA_WIDTH : ekt_pkg::FoundW;

  // Cell outputs along the ring.
  logic                      cv_w [CAPACITY];
  logic [ekt_pkg::KeyW-1:0]  ck_w [CAPACITY];
  logic [PW-1:0]             cp_w [CAPACITY];
  logic [ekt_pkg::TimeW-1:0] cd_w [CAPACITY];

  // Tail write-back from the sequencer.
  logic                      fb_valid;
  logic [ekt_pkg::KeyW-1:0]  fb_key;
  logic [PW-1:0]             fb_payload;
  logic [ekt_pkg::TimeW-1:0] fb_deadline;

  logic           shift;
  logic           take;
  ekt_pkg::stat_t stat;
  ekt_pkg::res_t  res;

  logic           out_valid_q;
  ekt_pkg::res_t  res_q;

  // Ring: cell i loads from cell i+1, the last cell from the sequencer.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    if (gi == CAPACITY - 1) begin : g_tail
      ekt_cell #(.PW(PW)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (shift),
        .valid_i    (fb_valid),
        .key_i      (fb_key),
        .payload_i  (fb_payload),
        .deadline_i (fb_deadline),
        .valid_o    (cv_w[gi]),
        .key_o      (ck_w[gi]),
        .payload_o  (cp_w[gi]),
        .deadline_o (cd_w[gi])
      );
    end else begin : g_body
      ekt_cell #(.PW(PW)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (shift),
        .valid_i    (cv_w[gi+1]),
        .key_i      (ck_w[gi+1]),
        .payload_i  (cp_w[gi+1]),
        .deadline_i (cd_w[gi+1]),
        .valid_o    (cv_w[gi]),
        .key_o      (ck_w[gi]),
        .payload_o  (cp_w[gi]),
        .deadline_o (cd_w[gi])
      );
    end
  end

  ekt_ctrl #(
    .CAPACITY (CAPACITY),
    .PW       (PW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .data_i          (entry_data_i[PW-1:0]),
    .timeout_i       (timeout_ticks_i),
    .elapsed_i       (elapsed_ticks_i),
    .take_i          (take),
    .head_valid_i    (cv_w[0]),
    .head_key_i      (ck_w[0]),
    .head_payload_i  (cp_w[0]),
    .head_deadline_i (cd_w[0]),
    .fb_valid_o      (fb_valid),
    .fb_key_o        (fb_key),
    .fb_payload_o    (fb_payload),
    .fb_deadline_o   (fb_deadline),
    .shift_o         (shift),
    .stat_o          (stat),
    .res_o           (res)
  );

  // A finished result moves into the output register once it is free.
  assign take = stat.done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign in_stall_o   = stat.busy;
  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign found_data_o = res_q.found_data;
  assign live_count_o = res_q.live_count;

  // An accepted request always leaves the idle state.
  `EKT_CHECK_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o)
  // An empty table has a cleared time base and no earliest deadline.
  `EKT_CHECK(a_empty_clean, stat.empty, stat.tb_zero && stat.no_min)

endmodule
